FILE: sv/pls_pkg.sv
// Shared types and constants for the positional list store.
package pls_pkg;

    localparam int DATA_W  = 32;
    localparam int FUNC_W  = 2;
    localparam int POS_W   = 7;
    localparam int LEN_W   = 7;
    localparam int GROUP_W = 8;
    localparam int GIDX_W  = $clog2(GROUP_W);

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOCATE = 2'd2;

    typedef logic signed [DATA_W-1:0] item_t;

    typedef struct packed {
        logic ins;
        logic del;
    } cell_cmd_t;

    typedef struct packed {
        logic done;
        logic hit;
    } scan_status_t;

endpackage

FILE: sv/pls_cell.sv
// One list entry: holds a value, shifts with its neighbors, compares against a key.
module pls_cell #(
    parameter int IDX = 0,
    parameter int PW  = 8
) (
    input  logic              clk,
    input  pls_pkg::cell_cmd_t cmd,
    input  logic [PW-1:0]     pos_m1,
    input  logic [PW-1:0]     count,
    input  pls_pkg::item_t    key,
    input  pls_pkg::item_t    left_data,
    input  pls_pkg::item_t    right_data,
    output pls_pkg::item_t    data,
    output pls_pkg::item_t    sel_data,
    output logic              match
);
    import pls_pkg::*;

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    item_t data_reg;
    item_t data_next;
    logic  at_pos;
    logic  above;

    assign at_pos = (MY_IDX == pos_m1);
    assign above  = (MY_IDX > pos_m1);

    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins)
        begin
            if (at_pos)
            begin
                data_next = key;
            end
            else if (above)
            begin
                data_next = left_data;
            end
        end
        else if (cmd.del)
        begin
            if (at_pos || above)
            begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign sel_data = (cmd.del && at_pos) ? data_reg : '0;
    assign match    = (data_reg == key) && (MY_IDX < count);

endmodule

FILE: sv/pls_scan.sv
// First-match search over the cell match flags, one group of flags per cycle.
module pls_scan #(
    parameter int CAPACITY = 64,
    parameter int PW       = 8
) (
    input  logic                  clk,
    input  logic                  load,
    input  logic [CAPACITY-1:0]   match_vec,
    output pls_pkg::scan_status_t status,
    output logic [PW-1:0]         found_pos
);
    import pls_pkg::*;

    localparam int NG = (CAPACITY + GROUP_W - 1) / GROUP_W;
    localparam int FW = NG * GROUP_W;

    logic [FW-1:0]      flags_reg;
    logic [FW-1:0]      flags_next;
    logic [PW-1:0]      base_reg;
    logic [PW-1:0]      base_next;
    logic [GROUP_W-1:0] low;
    logic [GIDX_W-1:0]  idx;
    logic               hit;
    logic               done;

    assign low  = flags_reg[GROUP_W-1:0];
    assign hit  = |low;
    assign done = hit || (flags_reg == '0);

    // Lowest set flag in the current group wins.
    always_comb
    begin
        idx = '0;
        for (int k = GROUP_W - 1; k >= 0; k--)
        begin
            if (low[k])
            begin
                idx = GIDX_W'(k);
            end
        end
    end

    always_comb
    begin
        flags_next = flags_reg;
        base_next  = base_reg;
        if (load)
        begin
            flags_next = FW'(match_vec);
            base_next  = '0;
        end
        else if (!done)
        begin
            flags_next = flags_reg >> GROUP_W;
            base_next  = base_reg + PW'(GROUP_W);
        end
    end

    always_ff @(posedge clk)
    begin
        flags_reg <= flags_next;
        base_reg  <= base_next;
    end

    assign status.done = done;
    assign status.hit  = hit;
    assign found_pos   = base_reg + PW'(idx) + PW'(1);

endmodule

FILE: sv/positional_list_store.sv
// Top level of the positional list store: cell chain, locate scan, length count and result register.
//
//  channel | signals                                      | dir | handshake
//  --------+----------------------------------------------+-----+-----------------
//  in      | func, position, item_value                   | in  | in_valid/in_ready
//  out     | success, removed_value, found_position,      | out | out_valid/out_ready
//          | list_length                                  |     |
//
// Insert, delete and unused requests finish in the cycle they are accepted.
// Locate captures the match flags of all cells at accept, then scans them eight cells per
// cycle until the first match or until no set flag is left.
// Reset empties the list; entry storage itself is not cleared and needs no sweep.
// A new request is taken while no locate scan is in progress and the result register is free or being drained.
module positional_list_store #(
    parameter int CAPACITY = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pls_pkg::FUNC_W-1:0]    func,
    input  logic [pls_pkg::POS_W-1:0]     position,
    input  pls_pkg::item_t                item_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          success,
    output pls_pkg::item_t                removed_value,
    output logic [pls_pkg::POS_W-1:0]     found_position,
    output logic [pls_pkg::LEN_W-1:0]     list_length
);
    import pls_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                state_reg;
    logic                state_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                success_reg;
    logic                success_next;
    item_t               removed_reg;
    item_t               removed_next;
    logic [POS_W-1:0]    found_reg;
    logic [POS_W-1:0]    found_next;
    logic [LEN_W-1:0]    length_reg;
    logic [LEN_W-1:0]    length_next;

    logic                out_free;
    logic                accept;
    logic                is_locate;
    logic                ins_ok;
    logic                del_ok;
    logic                scan_finish;
    logic [PW-1:0]       pos_ext;
    logic [PW-1:0]       cnt_ext;
    logic [PW-1:0]       pos_m1;
    logic [PW-1:0]       len_ext;
    cell_cmd_t           cmd;
    item_t               removed_sum;
    item_t               cell_data [CAPACITY];
    item_t               cell_sel  [CAPACITY];
    logic [CAPACITY-1:0] match_vec;
    scan_status_t        scan_st;
    logic [PW-1:0]       scan_pos;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept    = in_valid && in_ready;
    assign is_locate = (func == FUNC_LOCATE);

    assign pos_ext = PW'(position);
    assign cnt_ext = PW'(count_reg);
    assign pos_m1  = pos_ext - PW'(1);

    assign ins_ok = (func == FUNC_INSERT) && (pos_ext != '0)
                    && (pos_ext <= cnt_ext + PW'(1)) && (cnt_ext < PW'(CAPACITY));
    assign del_ok = (func == FUNC_DELETE) && (pos_ext != '0) && (pos_ext <= cnt_ext);

    assign cmd.ins = accept && ins_ok;
    assign cmd.del = accept && del_ok;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            item_t left_d;
            item_t right_d;
            if (gi == 0)
            begin : g_first
                assign left_d = item_value;
            end
            else
            begin : g_mid_l
                assign left_d = cell_data[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_d = cell_data[gi];
            end
            else
            begin : g_mid_r
                assign right_d = cell_data[gi+1];
            end

            pls_cell #(
                .IDX (gi),
                .PW  (PW)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .pos_m1     (pos_m1),
                .count      (cnt_ext),
                .key        (item_value),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[gi]),
                .sel_data   (cell_sel[gi]),
                .match      (match_vec[gi])
            );
        end
    endgenerate

    // Only the addressed cell drives a nonzero value, so an OR collects it.
    always_comb
    begin
        removed_sum = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            removed_sum = removed_sum | cell_sel[k];
        end
    end

    pls_scan #(
        .CAPACITY (CAPACITY),
        .PW       (PW)
    ) u_scan (
        .clk       (clk),
        .load      (accept && is_locate),
        .match_vec (match_vec),
        .status    (scan_st),
        .found_pos (scan_pos)
    );

    assign scan_finish = (state_reg == ST_SCAN) && scan_st.done && out_free;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.del)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    assign len_ext = PW'(count_next);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_locate)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        success_next   = success_reg;
        removed_next   = removed_reg;
        found_next     = found_reg;
        length_next    = length_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (accept && !is_locate)
        begin
            success_next   = cmd.ins || cmd.del;
            removed_next   = removed_sum;
            found_next     = '0;
            length_next    = len_ext[LEN_W-1:0];
            out_valid_next = 1'b1;
        end
        else if (scan_finish)
        begin
            success_next   = scan_st.hit;
            removed_next   = '0;
            found_next     = scan_st.hit ? scan_pos[POS_W-1:0] : '0;
            length_next    = len_ext[LEN_W-1:0];
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        success_reg <= success_next;
        removed_reg <= removed_next;
        found_reg   <= found_next;
        length_reg  <= length_next;
    end

    assign out_valid      = out_valid_reg;
    assign success        = success_reg;
    assign removed_value  = removed_reg;
    assign found_position = found_reg;
    assign list_length    = length_reg;

endmodule
